@@ rtl/core/acs_pkg.sv @@
// ----------------------------------------------------------------------------
// acs_pkg: shared definitions for the 16-to-8 bit contrast stretch
// Holds field widths, operation and register codes, and the queue entry that
// travels from the classifying front end to the dividing back end.
// ----------------------------------------------------------------------------
package acs_pkg;

	localparam int PIX_W      = 16;
	localparam int OUT_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Numerator (p - lo) * 510 + d stays below 511 * 65535 < 2**25.
	localparam int NUM_W      = 25;
	localparam int QUOT_STEPS = OUT_W;
	localparam int STEP_W     = $clog2(QUOT_STEPS);

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [OUT_W-1:0] OUT_MAX  = 8'd255;
	localparam logic [OUT_W-1:0] OUT_ZERO = 8'd0;

	// Item operations.
	localparam logic OP_MEASURE = 1'b0;
	localparam logic OP_CONVERT = 1'b1;

	// Window source selection.
	localparam logic WIN_MEASURED   = 1'b0;
	localparam logic WIN_CONFIGURED = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SOURCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LOW    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HIGH   = 2'd2;

	// One classified item waiting for the back end.
	typedef struct packed {
		logic             need_div;
		logic [OUT_W-1:0] fixed_pixel;
		logic [PIX_W-1:0] offset;
		logic [PIX_W-1:0] span;
		logic [PIX_W-1:0] low_seen;
		logic [PIX_W-1:0] high_seen;
	} acs_entry_t;

endpackage

@@ rtl/core/auto_contrast_16_to_8_top.sv @@
// ----------------------------------------------------------------------------
// auto_contrast_16_to_8_top: min/max contrast stretch, 16-bit to 8-bit pixels
// Measures a running pixel range and maps pixels into 8 bits over a window.
// ----------------------------------------------------------------------------
// Every accepted item gives one result, in order. Measure items, and convert
// items below the window or on or above its upper edge, pass the queue and
// output register at one item per cycle unless the output stalls or a
// division is ahead of them. A convert item inside the window goes through the
// back end's restoring divider, one quotient bit per cycle: a load, a step per
// quotient bit and a write; it takes no new item before the write. A two-entry
// queue keeps input transfers going while a division runs, until it fills.
// Configuration must be written through cfg_we, cfg_index and cfg_data only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module auto_contrast_16_to_8_top
	import acs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  opcode,
	input  logic [PIX_W-1:0]      pixel,
	input  logic                  frame_start,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_W-1:0]      out_pixel,
	output logic [PIX_W-1:0]      low_seen,
	output logic [PIX_W-1:0]      high_seen,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic       q_push;
	logic       q_full;
	logic       q_pop;
	logic       q_valid;
	acs_entry_t q_in;
	acs_entry_t q_head;

	// Front end: range tracking and classification.
	acs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.pixel       (pixel),
		.frame_start (frame_start),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_push      (q_push),
		.q_entry     (q_in),
		.q_full      (q_full)
	);

	// Queue between the two halves.
	acs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_entry (q_head)
	);

	// Back end: division and output register.
	acs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_pixel (out_pixel),
		.low_seen  (low_seen),
		.high_seen (high_seen)
	);

endmodule

@@ rtl/core/acs_front.sv @@
// ----------------------------------------------------------------------------
// acs_front: input acceptance and item classification
// Holds the configuration and the running range, folds measure items into
// the range and reduces convert items to a fixed result or a division job.
// ----------------------------------------------------------------------------
module acs_front
	import acs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  opcode,
	input  logic [PIX_W-1:0]      pixel,
	input  logic                  frame_start,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  q_push,
	output acs_entry_t            q_entry,
	input  logic                  q_full
);

	logic             win_src_q;
	logic [PIX_W-1:0] win_low_q;
	logic [PIX_W-1:0] win_high_q;
	logic [PIX_W-1:0] run_min_q;
	logic [PIX_W-1:0] run_max_q;
	logic [PIX_W-1:0] next_min;
	logic [PIX_W-1:0] next_max;
	logic [PIX_W-1:0] lo;
	logic [PIX_W-1:0] hi;
	logic [PIX_W-1:0] offset;
	logic [PIX_W-1:0] span;
	logic             accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign q_push   = accept;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_src_q  <= WIN_MEASURED;
			win_low_q  <= '0;
			win_high_q <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WINDOW_SOURCE: win_src_q  <= cfg_data[0];
				CFG_WINDOW_LOW:    win_low_q  <= cfg_data;
				CFG_WINDOW_HIGH:   win_high_q <= cfg_data;
				default:           win_src_q  <= win_src_q;
			endcase
		end
	end

	// Running range after this item; convert items leave it alone.
	always_comb begin
		next_min = run_min_q;
		next_max = run_max_q;
		if (opcode == OP_MEASURE) begin
			if (frame_start) begin
				next_min = pixel;
				next_max = pixel;
			end else begin
				if (pixel < run_min_q) next_min = pixel;
				if (pixel > run_max_q) next_max = pixel;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_min_q <= '0;
			run_max_q <= '0;
		end else if (accept) begin
			run_min_q <= next_min;
			run_max_q <= next_max;
		end
	end

	// Window selection and classification of the convert result.
	assign lo     = (win_src_q == WIN_CONFIGURED) ? win_low_q  : run_min_q;
	assign hi     = (win_src_q == WIN_CONFIGURED) ? win_high_q : run_max_q;
	assign offset = pixel - lo;
	assign span   = hi - lo;

	always_comb begin
		q_entry.need_div    = 1'b0;
		q_entry.fixed_pixel = OUT_ZERO;
		q_entry.offset      = offset;
		q_entry.span        = span;
		q_entry.low_seen    = next_min;
		q_entry.high_seen   = next_max;
		if (opcode == OP_CONVERT) begin
			if (hi <= lo) begin
				// Empty or inverted window acts as a threshold at the lower edge.
				q_entry.fixed_pixel = (pixel <= lo) ? OUT_ZERO : OUT_MAX;
			end else if (pixel < lo) begin
				q_entry.fixed_pixel = OUT_ZERO;
			end else if (offset >= span) begin
				// At or above the upper edge the quotient reaches full scale.
				q_entry.fixed_pixel = OUT_MAX;
			end else begin
				q_entry.need_div = 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/acs_queue.sv @@
// ----------------------------------------------------------------------------
// acs_queue: short FIFO between front end and back end
// Keeps classified items in order so that each side can stall on its own.
// ----------------------------------------------------------------------------
module acs_queue
	import acs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  acs_entry_t push_entry,
	output logic       full,
	input  logic       pop,
	output logic       head_valid,
	output acs_entry_t head_entry
);

	acs_entry_t        store_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = store_q[rd_ptr_q];

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |-> !push)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue read while empty");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue fill level out of range");
`endif

endmodule

@@ rtl/core/acs_back.sv @@
// ----------------------------------------------------------------------------
// acs_back: division and result register
// Passes fixed results straight to the output register and runs a restoring
// divider, one quotient bit per cycle, for pixels inside the window.
// ----------------------------------------------------------------------------
module acs_back
	import acs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  acs_entry_t       q_head,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] out_pixel,
	output logic [PIX_W-1:0] low_seen,
	output logic [PIX_W-1:0] high_seen
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_DONE = 3'b100
	} back_state_t;

	back_state_t       state_q;
	logic [NUM_W-1:0]  rem_q;
	logic [NUM_W-1:0]  dvs_q;
	logic [OUT_W-1:0]  quot_q;
	logic [STEP_W-1:0] cnt_q;
	logic [PIX_W-1:0]  lows_q;
	logic [PIX_W-1:0]  highs_q;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_pixel_q;
	logic [PIX_W-1:0]  low_seen_q;
	logic [PIX_W-1:0]  high_seen_q;
	logic              slot_free;
	logic              load_div;
	logic              emit_fixed;
	logic              emit_div;
	logic [NUM_W-1:0]  offset_w;
	logic [NUM_W-1:0]  numer;
	logic              bit_set;

	assign slot_free  = !out_valid_q || out_ready;
	assign load_div   = (state_q == S_IDLE) && q_valid && q_head.need_div;
	assign emit_fixed = (state_q == S_IDLE) && q_valid && !q_head.need_div && slot_free;
	assign emit_div   = (state_q == S_DONE) && slot_free;
	assign q_pop      = load_div || emit_fixed;

	// Numerator (offset * 510 + span) built from shifts.
	assign offset_w = NUM_W'(q_head.offset);
	assign numer    = (offset_w << 9) - (offset_w << 1) + NUM_W'(q_head.span);
	assign bit_set  = (rem_q >= dvs_q);

	// Divider sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (load_div) begin
						state_q <= S_DIV;
						cnt_q   <= STEP_W'(QUOT_STEPS - 1);
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) state_q <= S_DONE;
				end
				S_DONE: begin
					if (emit_div) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Divider datapath: the divisor 2 * span starts aligned to the top quotient bit.
	always_ff @(posedge clk) begin
		if (load_div) begin
			rem_q   <= numer;
			dvs_q   <= NUM_W'({q_head.span, 1'b0}) << (QUOT_STEPS - 1);
			quot_q  <= '0;
			lows_q  <= q_head.low_seen;
			highs_q <= q_head.high_seen;
		end else if (state_q == S_DIV) begin
			if (bit_set) rem_q <= rem_q - dvs_q;
			dvs_q  <= dvs_q >> 1;
			quot_q <= {quot_q[OUT_W-2:0], bit_set};
		end
	end

	// Output register; a waiting result stalls emits but not the loading of a division.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fixed || emit_div) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fixed) begin
			out_pixel_q <= q_head.fixed_pixel;
			low_seen_q  <= q_head.low_seen;
			high_seen_q <= q_head.high_seen;
		end else if (emit_div) begin
			out_pixel_q <= quot_q;
			low_seen_q  <= lows_q;
			high_seen_q <= highs_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pixel = out_pixel_q;
	assign low_seen  = low_seen_q;
	assign high_seen = high_seen_q;

`ifndef ASSERT_OFF
	a_div_counts_down: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) && (cnt_q != '0) |=> (state_q == S_DIV) && (cnt_q == $past(cnt_q) - 1'b1))
		else $error("divider step count broken");

	a_load_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		load_div |=> (state_q == S_DIV) && (cnt_q == STEP_W'(QUOT_STEPS - 1)))
		else $error("division job not started");

	a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !q_pop)
		else $error("queue popped while divider busy");
`endif

endmodule
